// ===== rtl/mexp_pkg.sv =====
// Package for the modular exponentiation block: widths, iteration counts and
// the command and status structs between the controller and the datapath.
// Depends on nothing.
package mexp_pkg;

	localparam int MODULUS_BITS  = 31;
	localparam int EXPONENT_BITS = 63;
	localparam int BASE_BITS     = 63;
	localparam int PROD_BITS     = 2 * MODULUS_BITS;

	localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(998244353);

	// Remainder steps done by a reducer in one cycle.
	localparam int RED_STEPS   = 4;
	localparam int BASE_CYCLES = (BASE_BITS + RED_STEPS - 1) / RED_STEPS;
	localparam int PROD_CYCLES = (MODULUS_BITS + RED_STEPS - 1) / RED_STEPS;
	localparam int PROD_SHIFT  = PROD_CYCLES * RED_STEPS;
	localparam int SHR_W       = BASE_CYCLES * RED_STEPS;
	localparam int CNT_W       = $clog2(BASE_CYCLES);

	typedef struct packed {
		logic load_in;
		logic load_prod;
		logic red_step;
		logic upd_pw;
		logic upd_exp;
		logic finish;
	} mexp_cmd_t;

	typedef struct packed {
		logic mod_small;
		logic exp_zero;
		logic exp_upper_zero;
	} mexp_sts_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: base to the exponent modulo
// a configured modulus. Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
//   channel   handshake             payload
//   input     start, busy           base_value, exponent_value
//   result    done (strobe)         power_residue
//   config    modulus_we            modulus_wdata
//
// A beat is taken at an edge with start high and busy low. The base is first
// reduced; then each exponent bit, up to the highest set one, takes a multiply,
// the remainder steps and an update, and a zero exponent takes no iteration.
// A modulus below two goes straight to the finish and gives a zero result.
// Reset restores the modulus to 998244353; busy falls in the strobe cycle, so
// the next beat may be taken then. The receiver cannot stall the result.
module modular_exponentiation
	import mexp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [BASE_BITS-1:0]     base_value,
	input  logic [EXPONENT_BITS-1:0] exponent_value,
	output logic                     done,
	output logic [MODULUS_BITS-1:0]  power_residue,
	input  logic                     modulus_we,
	input  logic [MODULUS_BITS-1:0]  modulus_wdata
);

	mexp_cmd_t cmd;
	mexp_sts_t sts;

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mexp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.modulus_we     (modulus_we),
		.modulus_wdata  (modulus_wdata),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.cmd            (cmd),
		.sts            (sts),
		.power_residue  (power_residue)
	);

endmodule

// ===== rtl/mexp_red.sv =====
// Radix-2 restoring remainder unit that retires RED_STEPS dividend bits per cycle while step is high.
// Depends on mexp_pkg.
module mexp_red
	import mexp_pkg::*;
(
	input  logic                    clk,
	input  logic                    load,
	input  logic                    step,
	input  logic [MODULUS_BITS-1:0] load_rem,
	input  logic [SHR_W-1:0]        load_shr,
	input  logic [MODULUS_BITS-1:0] modulus,
	output logic [MODULUS_BITS-1:0] rem
);

	logic [MODULUS_BITS-1:0] rem_q;
	logic [SHR_W-1:0]        shr_q;
	logic [MODULUS_BITS-1:0] rem_nx;

	always_comb begin
		logic [MODULUS_BITS:0]   t;
		logic [MODULUS_BITS-1:0] r;
		r = rem_q;
		for (int k = 0; k < RED_STEPS; k++) begin
			t = {r, shr_q[SHR_W-1-k]};
			if (t >= {1'b0, modulus}) begin
				t = t - {1'b0, modulus};
			end
			r = t[MODULUS_BITS-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= load_rem;
			shr_q <= load_shr;
		end else if (step) begin
			rem_q <= rem_nx;
			shr_q <= shr_q << RED_STEPS;
		end
	end

	assign rem = rem_q;

endmodule

// ===== rtl/mexp_dp.sv =====
// Datapath: modulus register, running power and result, exponent shifter,
// two multipliers and two remainder units. Depends on mexp_pkg and mexp_red.
module mexp_dp
	import mexp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     modulus_we,
	input  logic [MODULUS_BITS-1:0]  modulus_wdata,
	input  logic [BASE_BITS-1:0]     base_value,
	input  logic [EXPONENT_BITS-1:0] exponent_value,
	input  mexp_cmd_t                cmd,
	output mexp_sts_t                sts,
	output logic [MODULUS_BITS-1:0]  power_residue
);

	logic [MODULUS_BITS-1:0]  modulus_q;
	logic [MODULUS_BITS-1:0]  pw_q;
	logic [MODULUS_BITS-1:0]  acc_q;
	logic [EXPONENT_BITS-1:0] exp_q;
	logic [MODULUS_BITS-1:0]  res_q;
	logic [PROD_BITS-1:0]     prod_sq;
	logic [PROD_BITS-1:0]     prod_mul;
	logic [MODULUS_BITS-1:0]  sq_load_rem;
	logic [SHR_W-1:0]         sq_load_shr;
	logic [MODULUS_BITS-1:0]  sq_rem;
	logic [MODULUS_BITS-1:0]  mul_rem;
	logic                     red_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	assign prod_sq  = PROD_BITS'(pw_q) * PROD_BITS'(pw_q);
	assign prod_mul = PROD_BITS'(acc_q) * PROD_BITS'(pw_q);

	// The high part of a product of two residues is already below the modulus.
	always_comb begin
		if (cmd.load_in) begin
			sq_load_rem = '0;
			sq_load_shr = SHR_W'(base_value);
		end else begin
			sq_load_rem = MODULUS_BITS'(prod_sq >> PROD_SHIFT);
			sq_load_shr = SHR_W'(prod_sq) << (SHR_W - PROD_SHIFT);
		end
	end

	assign red_load = cmd.load_in | cmd.load_prod;

	mexp_red u_red_sq (
		.clk      (clk),
		.load     (red_load),
		.step     (cmd.red_step),
		.load_rem (sq_load_rem),
		.load_shr (sq_load_shr),
		.modulus  (modulus_q),
		.rem      (sq_rem)
	);

	mexp_red u_red_mul (
		.clk      (clk),
		.load     (cmd.load_prod),
		.step     (cmd.red_step),
		.load_rem (MODULUS_BITS'(prod_mul >> PROD_SHIFT)),
		.load_shr (SHR_W'(prod_mul) << (SHR_W - PROD_SHIFT)),
		.modulus  (modulus_q),
		.rem      (mul_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			acc_q <= MODULUS_BITS'(1);
			exp_q <= exponent_value;
		end else if (cmd.upd_exp) begin
			if (exp_q[0]) begin
				acc_q <= mul_rem;
			end
			exp_q <= exp_q >> 1;
		end
		if (cmd.upd_pw) begin
			pw_q <= sq_rem;
		end
		if (cmd.finish) begin
			res_q <= sts.mod_small ? '0 : acc_q;
		end
	end

	assign sts.mod_small      = (modulus_q < MODULUS_BITS'(2));
	assign sts.exp_zero       = (exp_q == '0);
	assign sts.exp_upper_zero = ((exp_q >> 1) == '0);
	assign power_residue      = res_q;

endmodule

// ===== rtl/mexp_ctrl.sv =====
// Controller state machine that sequences base reduction and the
// square-and-multiply iterations. Depends on mexp_pkg.
module mexp_ctrl
	import mexp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mexp_sts_t sts,
	output mexp_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_PW0,
		ST_LOAD,
		ST_RUN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= CNT_W'(BASE_CYCLES - 1);
						state_q <= sts.mod_small ? ST_FINISH : ST_BASE;
					end
				end
				ST_BASE: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_PW0;
					end
				end
				ST_PW0: begin
					state_q <= sts.exp_zero ? ST_FINISH : ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= CNT_W'(PROD_CYCLES - 1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= sts.exp_upper_zero ? ST_FINISH : ST_LOAD;
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load_in   = (state_q == ST_IDLE) && start;
		cmd.load_prod = (state_q == ST_LOAD);
		cmd.red_step  = (state_q == ST_BASE) || (state_q == ST_RUN);
		cmd.upd_pw    = (state_q == ST_PW0) || (state_q == ST_UPDATE);
		cmd.upd_exp   = (state_q == ST_UPDATE);
		cmd.finish    = (state_q == ST_FINISH);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
